### hw/rtl/nmea_sentence_checker_defines.svh
// Assertion macros for the sentence checker's port-level assertions in nsc_checker.sv.
// Depends on nothing; the using module must provide aclk and aresetn.
`ifndef NMEA_SENTENCE_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_CHECKER_DEFINES_SVH

// Checked at every clock edge outside reset.
`define NSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define NSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hw/rtl/nsc_pkg.sv
// Shared types, character codes and verdict codes for the NMEA sentence checker.
// Depends on nothing.
`timescale 1ns / 1ps

package nsc_pkg;

    localparam int unsigned NSC_STATUS_FIELD = 2;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_A      = 8'h41;

    localparam logic [3:0] FIELD_MAX = 4'd15;

    localparam logic [1:0] VERDICT_NONE     = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
    localparam logic [1:0] VERDICT_MISMATCH = 2'd2;
    localparam logic [1:0] VERDICT_INACTIVE = 2'd3;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic [3:0] field_number;
        logic       in_body;
        logic       sentence_end;
        logic [1:0] verdict;
    } nsc_result_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.bad   = 1'b0;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            d.value = c[3:0] + 4'd9;
        end else begin
            d.bad = 1'b1;
        end
        return d;
    endfunction

endpackage

### hw/rtl/nsc_parser.sv
// Sentence state and per-word parsing: checksum XOR, field count, status capture,
// hex checksum digits and the verdict on carriage return. Depends on nsc_pkg.
`timescale 1ns / 1ps

module nsc_parser import nsc_pkg::*; #(
    parameter int unsigned STATUS_FIELD = NSC_STATUS_FIELD
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output nsc_result_t result
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_STAT = 3'd2;
    localparam logic [2:0] PH_HEX1 = 3'd3;
    localparam logic [2:0] PH_HEX2 = 3'd4;
    localparam logic [2:0] PH_WAIT = 3'd5;

    localparam logic [3:0] STATUS_IDX = 4'(STATUS_FIELD);

    logic [2:0] phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic [3:0] count_reg, count_next;
    logic       active_reg, active_next;
    logic [7:0] sum_reg, sum_next;
    logic       bad_reg, bad_next;

    hex_digit_t digit;
    logic [3:0] count_inc;

    assign digit     = hex_decode(rx_byte);
    assign count_inc = (count_reg < FIELD_MAX) ? count_reg + 4'd1 : count_reg;

    always_comb begin
        phase_next  = phase_reg;
        xor_next    = xor_reg;
        count_next  = count_reg;
        active_next = active_reg;
        sum_next    = sum_reg;
        bad_next    = bad_reg;

        result.echo_byte    = rx_byte;
        result.field_number = 4'd0;
        result.in_body      = 1'b0;
        result.sentence_end = 1'b0;
        result.verdict      = VERDICT_NONE;

        if (rx_byte == CHAR_DOLLAR) begin
            xor_next    = 8'd0;
            count_next  = 4'd0;
            active_next = 1'b0;
            sum_next    = 8'd0;
            bad_next    = 1'b0;
            phase_next  = PH_BODY;
        end else begin
            unique case (phase_reg)
                PH_BODY, PH_STAT: begin
                    if (rx_byte == CHAR_CR) begin
                        result.sentence_end = 1'b1;
                        result.verdict      = VERDICT_MISMATCH;
                        phase_next          = PH_IDLE;
                    end else if (rx_byte == CHAR_STAR) begin
                        phase_next = PH_HEX1;
                    end else begin
                        result.in_body      = 1'b1;
                        result.field_number = count_reg;
                        xor_next            = xor_reg ^ rx_byte;
                        if (phase_reg == PH_STAT && rx_byte == CHAR_A) begin
                            active_next = 1'b1;
                        end
                        phase_next = PH_BODY;
                        if (rx_byte == CHAR_COMMA) begin
                            count_next = count_inc;
                            if (count_inc == STATUS_IDX) begin
                                phase_next = PH_STAT;
                            end
                        end
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    if (rx_byte == CHAR_CR) begin
                        result.sentence_end = 1'b1;
                        result.verdict      = VERDICT_MISMATCH;
                        phase_next          = PH_IDLE;
                    end else begin
                        if (digit.bad) begin
                            bad_next = 1'b1;
                        end
                        sum_next   = {sum_reg[3:0], digit.bad ? 4'd0 : digit.value};
                        phase_next = (phase_reg == PH_HEX1) ? PH_HEX2 : PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (rx_byte == CHAR_CR) begin
                        result.sentence_end = 1'b1;
                        if (bad_reg || sum_reg != xor_reg) begin
                            result.verdict = VERDICT_MISMATCH;
                        end else if (!active_reg) begin
                            result.verdict = VERDICT_INACTIVE;
                        end else begin
                            result.verdict = VERDICT_ACCEPTED;
                        end
                        phase_next = PH_IDLE;
                    end else begin
                        bad_next = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            xor_reg    <= 8'd0;
            count_reg  <= 4'd0;
            active_reg <= 1'b0;
            sum_reg    <= 8'd0;
            bad_reg    <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            xor_reg    <= xor_next;
            count_reg  <= count_next;
            active_reg <= active_next;
            sum_reg    <= sum_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

### hw/rtl/nmea_sentence_checker.sv
// NMEA 0183 sentence checker: one registered result word per received word.
// Throughput is one word per cycle while the skid stage is empty; the output register
// and a one-word skid stage let a word be taken while a finished result waits for m_ready.
// Synchronous active-low reset returns the parser to idle and empties the output.
// Depends on nsc_pkg and nsc_parser.
`timescale 1ns / 1ps

module nmea_sentence_checker import nsc_pkg::*; #(
    parameter int unsigned STATUS_FIELD = NSC_STATUS_FIELD
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_echo_byte,
    output logic [3:0] m_field_number,
    output logic       m_in_body,
    output logic       m_sentence_end,
    output logic [1:0] m_verdict
);

    nsc_result_t result;
    nsc_result_t main_reg, main_next;
    nsc_result_t skid_reg, skid_next;
    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    logic        take_in;
    logic        take_out;

    assign s_ready  = !skid_valid_reg;
    assign take_in  = s_valid && s_ready;
    assign take_out = main_valid_reg && m_ready;

    nsc_parser #(
        .STATUS_FIELD (STATUS_FIELD)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take_in),
        .rx_byte (s_rx_byte),
        .result  (result)
    );

    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take_out) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_next       = result;
                main_valid_next = take_in;
            end
        end else if (take_in) begin
            if (main_valid_reg) begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end else begin
                main_next       = result;
                main_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign m_valid        = main_valid_reg;
    assign m_echo_byte    = main_reg.echo_byte;
    assign m_field_number = main_reg.field_number;
    assign m_in_body      = main_reg.in_body;
    assign m_sentence_end = main_reg.sentence_end;
    assign m_verdict      = main_reg.verdict;

endmodule

### hw/rtl/nsc_checker.sv
// Port-level assertions for the NMEA sentence checker and the bind that attaches them.
// Depends on nsc_pkg and nmea_sentence_checker_defines.svh.
`timescale 1ns / 1ps
`include "nmea_sentence_checker_defines.svh"

module nsc_checker import nsc_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_echo_byte,
    input logic [3:0] m_field_number,
    input logic       m_in_body,
    input logic       m_sentence_end,
    input logic [1:0] m_verdict
);

    `NSC_ASSERT(a_verdict_only_at_end, m_valid && !m_sentence_end |-> m_verdict == VERDICT_NONE, "verdict outside sentence end")
    `NSC_ASSERT(a_end_has_verdict, m_valid && m_sentence_end |-> m_verdict != VERDICT_NONE && m_echo_byte == CHAR_CR && !m_in_body, "sentence end without verdict")
    `NSC_ASSERT(a_body_excludes_delims, m_valid && m_in_body |-> m_echo_byte != CHAR_DOLLAR && m_echo_byte != CHAR_STAR && m_echo_byte != CHAR_CR, "delimiter reported as body")
    `NSC_ASSERT(a_field_zero_outside, m_valid && !m_in_body |-> m_field_number == 4'd0, "field number outside body")
    `NSC_ASSERT(a_stall_holds, m_valid && !m_ready |=> m_valid && $stable(m_echo_byte), "result word changed while stalled")

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_echo_byte    (m_echo_byte),
    .m_field_number (m_field_number),
    .m_in_body      (m_in_body),
    .m_sentence_end (m_sentence_end),
    .m_verdict      (m_verdict)
);
